@@ rtl/core/ssd_pkg.sv @@
package ssd_pkg;

  localparam int DIGITS_DEFAULT      = 4;
  localparam int PERIOD_BITS_DEFAULT = 8;

  localparam int REG_DIGITS       = 4;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 32;
  localparam int ENABLE_W         = 4;
  localparam int SEGMENT_W        = 8;
  localparam int SYMBOL_W         = 4;
  localparam int DIGIT_W          = 2;
  localparam int PERIOD_FIELD_W   = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DIGITS_ON     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIODS = 1'd1;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [DIGIT_W-1:0]    digit;
    logic [SYMBOL_W-1:0]   symbol;
  } req_t;

  typedef struct packed {
    logic [ENABLE_W-1:0]   digit_enables;
    logic [SEGMENT_W-1:0]  segments;
  } rsp_t;

  function automatic logic [SEGMENT_W-1:0] seg_pattern(input logic [SYMBOL_W-1:0] sym);
    logic [SEGMENT_W-1:0] pat;
    case (sym)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/ssd_digit.sv @@
module ssd_digit
  import ssd_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  logic                   wr,
  input  logic [SYMBOL_W-1:0]    wr_symbol,
  input  logic                   on,
  input  logic [PERIOD_BITS-1:0] period,
  output logic [SYMBOL_W-1:0]    symbol,
  output logic                   flag_next
);

  logic [PERIOD_BITS-1:0] delay;
  logic [PERIOD_BITS-1:0] delay_next;
  logic                   flag;

  always_comb begin
    delay_next = delay;
    flag_next  = flag;
    if (delay != '0) begin
      delay_next = delay - 1'b1;
    end else if (period != '0) begin
      flag_next  = flag ^ on;
      delay_next = period;
    end else begin
      flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay  <= '0;
      flag   <= 1'b0;
      symbol <= '0;
    end else begin
      if (tick) begin
        delay <= delay_next;
        flag  <= flag_next;
      end
      if (wr) begin
        symbol <= wr_symbol;
      end
    end
  end

endmodule

@@ rtl/core/seven_segment_scan_blink_driver.sv @@
// Channel  Signals                        Payload
// req      req_valid / req_stall          req_data: opcode, digit, symbol
// rsp      rsp_valid / rsp_stall          rsp_data: digit_enables, segments
// cfg      cfg_write / cfg_index          cfg_data: digits_on, blink_periods
//
// A request passes through one input register, then the digit timers, scan
// step and pattern lookup into the response register.
// One request per cycle sustained; the response register is the only limit.
// rst is synchronous: clears timers, symbols, scan position and drive state.
// rsp_stall holds the response register; req_stall rises only when both
// registers are full.
module seven_segment_scan_blink_driver
  import ssd_pkg::*;
#(
  parameter int DIGITS      = DIGITS_DEFAULT,
  parameter int PERIOD_BITS = PERIOD_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_t                   req_data,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SCAN_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [ENABLE_W-1:0]   digits_on;
  logic [CFG_DATA_W-1:0] blink_periods;

  req_t                  item;
  logic                  item_full;
  logic                  load;
  logic                  accept;
  logic                  tick;
  logic                  is_write;

  logic [SCAN_W-1:0]     scan_position;
  logic [SCAN_W-1:0]     active;
  logic [ENABLE_W-1:0]   drive_enables;
  logic [SEGMENT_W-1:0]  drive_segments;
  logic [ENABLE_W-1:0]   enables_next;
  logic [SEGMENT_W-1:0]  segments_next;

  logic [DIGITS-1:0]     on_vec;
  logic [DIGITS-1:0]     flags_next;
  logic [SYMBOL_W-1:0]   symbols [DIGITS];

  assign load      = item_full && (!rsp_valid || !rsp_stall);
  assign req_stall = item_full && !load;
  assign accept    = req_valid && !req_stall;
  assign tick      = load && (item.opcode == OP_TICK);
  assign is_write  = load && (item.opcode == OP_WRITE);

  for (genvar i = 0; i < DIGITS; i++) begin : g_digit
    logic [PERIOD_BITS-1:0] period;
    logic                   wr;

    if (i < REG_DIGITS) begin : g_reg
      assign on_vec[i] = digits_on[i];
      assign period    = blink_periods[i*PERIOD_FIELD_W +: PERIOD_BITS];
    end else begin : g_none
      assign on_vec[i] = 1'b0;
      assign period    = '0;
    end

    assign wr = is_write && ({1'b0, item.digit} == 3'(i));

    ssd_digit #(
      .PERIOD_BITS(PERIOD_BITS)
    ) u_digit (
      .clk       (clk),
      .rst       (rst),
      .tick      (tick),
      .wr        (wr),
      .wr_symbol (item.symbol),
      .on        (on_vec[i]),
      .period    (period),
      .symbol    (symbols[i]),
      .flag_next (flags_next[i])
    );
  end

  always_comb begin
    active = (scan_position == '0) ? '0 : SCAN_W'(DIGITS) - scan_position;
    enables_next  = drive_enables;
    segments_next = drive_segments;
    if (item.opcode == OP_TICK) begin
      segments_next = seg_pattern(symbols[active]);
      if (on_vec[active] && !flags_next[active]) begin
        enables_next = ENABLE_W'(1) << active;
      end else begin
        enables_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_on      <= '0;
      blink_periods  <= '0;
      item_full      <= 1'b0;
      rsp_valid      <= 1'b0;
      scan_position  <= '0;
      drive_enables  <= '0;
      drive_segments <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DIGITS_ON:     digits_on     <= cfg_data[ENABLE_W-1:0];
          REG_BLINK_PERIODS: blink_periods <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        item_full <= 1'b1;
      end else if (load) begin
        item_full <= 1'b0;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (tick) begin
        scan_position  <= (scan_position == SCAN_W'(DIGITS - 1)) ? '0
                          : scan_position + 1'b1;
        drive_enables  <= enables_next;
        drive_segments <= segments_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req_data;
    end
    if (load) begin
      rsp_data.digit_enables <= enables_next;
      rsp_data.segments      <= segments_next;
    end
  end

endmodule
